FILE: rtl/sponge_hash_2048bit_permutation_defines.svh
// Assertion macros shared by the sponge hash RTL.
// Include by bare file name inside a module body; no other dependencies.
`ifndef SPONGE_HASH_2048BIT_PERMUTATION_DEFINES_SVH
`define SPONGE_HASH_2048BIT_PERMUTATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sph_pkg.sv
// Shared types and constant tables for the 2048-bit sponge hash.
// No dependencies; used by sph_round and the top level.
package sph_pkg;

    localparam int unsigned STATE_WORDS = 32;
    localparam int unsigned WORD_W      = 64;
    localparam int unsigned IDX_W       = 5;

    typedef logic [WORD_W-1:0]                   t_word;
    typedef logic [STATE_WORDS-1:0][WORD_W-1:0]  t_state;
    typedef logic [STATE_WORDS-1:0][WORD_W-1:0]  t_rc_tab;

    localparam t_word PAD_WORD = 64'h0000_0000_0000_0080;

    localparam int unsigned ROW_DEST [8] = '{1, 7, 5, 2, 4, 6, 0, 3};
    localparam int unsigned ROT_A    [8] = '{ 1,  2,  4,  7, 26, 49, 55, 58};
    localparam int unsigned ROT_B    [8] = '{ 3,  5, 15,  9, 46,  6, 19, 47};
    localparam int unsigned ROT_C    [8] = '{14, 23, 17, 12, 13, 50, 56, 61};
    localparam int unsigned ROT_D    [8] = '{36, 60, 24, 40, 37, 25, 57, 28};

    // Rotate left by a constant amount; amounts are fixed per row.
    function automatic t_word rol64(input t_word x, input int unsigned r);
        int unsigned s;
        s = r % 64;
        if (s == 0) begin
            return x;
        end
        return (x << s) | (x >> (64 - s));
    endfunction

    // Round constants from splitmix64 finalization, evaluated at elaboration.
    function automatic t_rc_tab rc_table();
        t_rc_tab t;
        t_word   x;
        for (int i = 0; i < STATE_WORDS; i++) begin
            x = 64'h9e37_79b9_7f4a_7c15 ^ 64'(i);
            x = x ^ (x >> 30);
            x = x * 64'hbf58_476d_1ce4_e5b9;
            x = x ^ (x >> 27);
            x = x * 64'h94d0_49bb_1331_11eb;
            x = x ^ (x >> 31);
            t[i] = x;
        end
        return t;
    endfunction

    localparam t_rc_tab RC_TAB = rc_table();

endpackage

FILE: rtl/sph_round.sv
// One permutation round of the 2048-bit sponge state, purely combinational.
// Depends on sph_pkg for the state type, row order, rotations and constants.
module sph_round (
    input  sph_pkg::t_state            i_state,
    input  logic [sph_pkg::IDX_W-1:0]  i_round_idx,
    output sph_pkg::t_state            o_state
);
    import sph_pkg::*;

    t_word x [8][4];
    t_word n [8][4];
    t_word p [8][4];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 4; j++) begin
                x[i][j] = i_state[i*4 + j];
            end
        end

        // Chi-like layer; row three is complemented.
        for (int j = 0; j < 4; j++) begin
            n[0][j] = x[0][j] ^ (~x[1][j] & x[2][j]);
            n[1][j] = x[4][j] ^ (~x[2][j] & x[0][j]);
            n[2][j] = x[3][j] ^ (~x[0][j] & x[1][j]);
            n[3][j] = ~x[1][j] ^ (~x[4][j] & ~x[5][j]);
            n[4][j] = x[2][j] ^ (~x[5][j] & x[6][j]);
            n[5][j] = x[5][j] ^ (~x[6][j] & x[7][j]);
            n[6][j] = x[6][j] ^ (~x[7][j] & x[3][j]);
            n[7][j] = x[7][j] ^ (~x[3][j] & x[4][j]);
        end

        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 4; j++) begin
                p[ROW_DEST[i]][j] = n[i][j];
            end
        end

        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 4; j++) begin
                o_state[i*4 + j] = p[i][j]
                    ^ rol64(p[i][(j + 1) % 4], ROT_A[i])
                    ^ rol64(p[i][(j + 2) % 4], ROT_B[i])
                    ^ rol64(p[i][(j + 3) % 4], ROT_C[i])
                    ^ rol64(p[i][j], ROT_D[i]);
            end
        end

        o_state[0] = o_state[0] ^ RC_TAB[i_round_idx];
    end

endmodule

FILE: rtl/sponge_hash_2048bit_permutation.sv
// Sequencing: a word that does not end a block is absorbed and the next word is taken without a stall.
// A word that ends a block runs a permutation of round_count rounds; a last word runs one too (two
// when its pad spills into a new block), then streams DIGEST_WORDS results, held by the output stall.
// Throughput is set by the single shared round unit, which does one round per cycle.
// Reset (synchronous, active low) clears the state, position and sequencer; round_count -> 15.
module sponge_hash_2048bit_permutation #(
    parameter int unsigned RATE_WORDS   = 20,
    parameter int unsigned DIGEST_WORDS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Message request channel.
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [63:0]              i_msg_word,
    input  logic [6:0]               i_valid_bits,
    input  logic                     i_last_word,
    // Digest result channel.
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [63:0]              o_digest_word,
    output logic                     o_digest_last,
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import sph_pkg::*;

    `include "sponge_hash_2048bit_permutation_defines.svh"

    // The sequencer idles waiting for a request, runs rounds through the
    // shared unit, and streams the digest out of word zero of the state.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PERM,
        S_OUT
    } t_fsm;

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(RATE_WORDS - 1);
    localparam logic [IDX_W-1:0] LAST_OUT = IDX_W'(DIGEST_WORDS - 1);
    localparam logic [4:0]       RC_RESET = 5'd15;

    t_fsm             r_fsm, n_fsm;
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_round, n_round;
    logic [IDX_W-1:0] r_ocnt, n_ocnt;
    logic             r_final, n_final;
    logic             r_padp, n_padp;
    logic [4:0]       r_round_count;

    t_state           round_out;
    logic             in_acc;
    logic             out_acc;
    logic             cfg_wr;
    logic             blk_end;
    logic             pad_now;
    t_word            masked_word;
    t_word            absorb_word;
    t_word            low_mask;
    logic [7:0]       part_byte;
    logic [7:0]       byte_mask;
    logic [7:0]       pad_bits;

    sph_round u_round (
        .i_state     (r_state),
        .i_round_idx (r_round),
        .o_state     (round_out)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    assign o_in_stall    = (r_fsm != S_IDLE);
    assign o_out_valid   = (r_fsm == S_OUT);
    assign o_digest_word = r_state[0];
    assign o_digest_last = (r_ocnt == LAST_OUT);

    // Register zero sits at byte address 0; anything at address 4 and up is ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {27'd0, r_round_count};

    // Padding of a short last word: whole valid bytes pass, the partial
    // byte keeps its top bits and takes the pad bit, later bytes clear.
    always_comb begin
        low_mask    = (64'd1 << {i_valid_bits[5:3], 3'b000}) - 64'd1;
        part_byte   = 8'(i_msg_word >> {i_valid_bits[5:3], 3'b000});
        byte_mask   = 8'(16'hFF00 >> i_valid_bits[2:0]);
        pad_bits    = 8'h80 >> i_valid_bits[2:0];
        masked_word = (i_msg_word & low_mask)
                    | (64'((part_byte & byte_mask) | pad_bits) << {i_valid_bits[5:3], 3'b000});
        absorb_word = (i_last_word && !i_valid_bits[6]) ? masked_word : i_msg_word;
    end

    assign blk_end = (r_pos == LAST_POS);
    // A full last word that does not end the block puts the pad into the next word now.
    assign pad_now = i_last_word && i_valid_bits[6] && !blk_end;

    always_comb begin
        n_fsm   = r_fsm;
        n_state = r_state;
        n_pos   = r_pos;
        n_round = r_round;
        n_ocnt  = r_ocnt;
        n_final = r_final;
        n_padp  = r_padp;
        unique case (r_fsm)
            S_IDLE: begin
                if (in_acc) begin
                    for (int k = 0; k < STATE_WORDS; k++) begin
                        if (IDX_W'(k) == r_pos) begin
                            n_state[k] = n_state[k] ^ absorb_word;
                        end
                        if (pad_now && (IDX_W'(k) == r_pos + IDX_W'(1))) begin
                            n_state[k] = n_state[k] ^ PAD_WORD;
                        end
                    end
                    n_round = '0;
                    if (!i_last_word) begin
                        if (blk_end) begin
                            n_pos = '0;
                            n_fsm = S_PERM;
                            n_final = 1'b0;
                        end else begin
                            n_pos = r_pos + IDX_W'(1);
                        end
                    end else begin
                        n_pos   = '0;
                        n_fsm   = S_PERM;
                        n_final = 1'b1;
                        // Full last word that filled the block: pad starts a new block.
                        n_padp  = i_valid_bits[6] && blk_end;
                    end
                end
            end
            S_PERM: begin
                if (r_round == r_round_count) begin
                    if (r_padp) begin
                        n_state[0] = r_state[0] ^ PAD_WORD;
                        n_padp     = 1'b0;
                        n_round    = '0;
                    end else if (r_final) begin
                        n_fsm  = S_OUT;
                        n_ocnt = '0;
                    end else begin
                        n_fsm = S_IDLE;
                    end
                end else begin
                    n_state = round_out;
                    n_round = r_round + IDX_W'(1);
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_ocnt == LAST_OUT) begin
                        n_state = '0;
                        n_fsm   = S_IDLE;
                        n_final = 1'b0;
                    end else begin
                        // Shift the state down so the next digest word sits in word zero.
                        n_state = r_state >> WORD_W;
                        n_ocnt  = r_ocnt + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm         <= S_IDLE;
            r_state       <= '0;
            r_pos         <= '0;
            r_round       <= '0;
            r_ocnt        <= '0;
            r_final       <= 1'b0;
            r_padp        <= 1'b0;
            r_round_count <= RC_RESET;
        end else begin
            r_fsm   <= n_fsm;
            r_state <= n_state;
            r_pos   <= n_pos;
            r_round <= n_round;
            r_ocnt  <= n_ocnt;
            r_final <= n_final;
            r_padp  <= n_padp;
            if (cfg_wr) begin
                r_round_count <= pwdata[4:0];
            end
        end
    end

    `SPH_ASSERT_NOW(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, o_in_stall,
        "input accepted while digest pending")
    `SPH_ASSERT_NEXT(a_last_ends_out, i_clk, i_rst_n, out_acc && o_digest_last,
        !o_out_valid && (r_state == '0) && (r_pos == '0), "state not cleared after digest")
    `SPH_ASSERT_NEXT(a_mid_block_fast, i_clk, i_rst_n, in_acc && !i_last_word && !blk_end,
        !o_in_stall, "mid-block word did not absorb in one cycle")
    `SPH_ASSERT_NOW(a_round_bound, i_clk, i_rst_n, r_fsm == S_PERM, r_round <= r_round_count,
        "round counter ran past round count")

endmodule

FILE: tb/sv/sph_tb_pkg.sv
`timescale 1ns / 1ps
// Digest predictor and scoreboard for the 2048-bit sponge hash testbench.
// Self-contained; used by tb_top.
package sph_tb_pkg;

    localparam int unsigned RATE_COUNT   = 20;
    localparam int unsigned DIGEST_COUNT = 6;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] REG_ROUND_COUNT = 3'd0;

    localparam logic [63:0] PAD_BYTE = 64'h80;

    // Row shuffle and per-row lane rotations of one round.
    localparam int unsigned ROW_MOVE  [8] = '{1, 7, 5, 2, 4, 6, 0, 3};
    localparam int unsigned ROT_LANE1 [8] = '{ 1,  2,  4,  7, 26, 49, 55, 58};
    localparam int unsigned ROT_LANE2 [8] = '{ 3,  5, 15,  9, 46,  6, 19, 47};
    localparam int unsigned ROT_LANE3 [8] = '{14, 23, 17, 12, 13, 50, 56, 61};
    localparam int unsigned ROT_SELF  [8] = '{36, 60, 24, 40, 37, 25, 57, 28};

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } t_digest_beat;

    class sph_digest_scoreboard;
        logic [63:0]  sponge [32];
        int unsigned  absorb_pos;
        int unsigned  rounds;
        t_digest_beat expected_q [$];
        int unsigned  mismatches;

        function new();
            clear_state();
            rounds     = 15;
            mismatches = 0;
        endfunction

        function void clear_state();
            foreach (sponge[k]) sponge[k] = '0;
            absorb_pos = 0;
        endfunction

        function void set_rounds(int unsigned r);
            rounds = r & 31;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        static function logic [63:0] rotl(logic [63:0] x, int unsigned r);
            if (r % 64 == 0) begin
                return x;
            end
            return (x << (r % 64)) | (x >> (64 - r % 64));
        endfunction

        static function logic [63:0] round_const(int unsigned idx);
            logic [63:0] x;
            x = 64'h9e37_79b9_7f4a_7c15 ^ 64'(idx);
            x = x ^ (x >> 30);
            x = x * 64'hbf58_476d_1ce4_e5b9;
            x = x ^ (x >> 27);
            x = x * 64'h94d0_49bb_1331_11eb;
            x = x ^ (x >> 31);
            return x;
        endfunction

        function void run_round(int unsigned idx);
            logic [63:0] a [8][4];
            logic [63:0] b [8][4];
            for (int i = 0; i < 8; i++)
                for (int j = 0; j < 4; j++)
                    a[i][j] = sponge[i*4 + j];
            for (int j = 0; j < 4; j++) begin
                b[0][j] = a[0][j] ^ (~a[1][j] & a[2][j]);
                b[1][j] = a[4][j] ^ (~a[2][j] & a[0][j]);
                b[2][j] = a[3][j] ^ (~a[0][j] & a[1][j]);
                b[3][j] = ~a[1][j] ^ (~a[4][j] & ~a[5][j]);
                b[4][j] = a[2][j] ^ (~a[5][j] & a[6][j]);
                b[5][j] = a[5][j] ^ (~a[6][j] & a[7][j]);
                b[6][j] = a[6][j] ^ (~a[7][j] & a[3][j]);
                b[7][j] = a[7][j] ^ (~a[3][j] & a[4][j]);
            end
            for (int i = 0; i < 8; i++)
                for (int j = 0; j < 4; j++)
                    a[ROW_MOVE[i]][j] = b[i][j];
            for (int i = 0; i < 8; i++)
                for (int j = 0; j < 4; j++)
                    sponge[i*4 + j] = a[i][j]
                        ^ rotl(a[i][(j + 1) % 4], ROT_LANE1[i])
                        ^ rotl(a[i][(j + 2) % 4], ROT_LANE2[i])
                        ^ rotl(a[i][(j + 3) % 4], ROT_LANE3[i])
                        ^ rotl(a[i][j], ROT_SELF[i]);
            sponge[0] ^= round_const(idx);
        endfunction

        function void permute_block();
            for (int unsigned r = 0; r < rounds; r++) run_round(r);
        endfunction

        function void absorb(logic [63:0] w);
            sponge[absorb_pos] ^= w;
            absorb_pos++;
            if (absorb_pos >= RATE_COUNT) begin
                permute_block();
                absorb_pos = 0;
            end
        endfunction

        // Called for every accepted message request; queues the digest on a last word.
        function void note_request(logic [63:0] w, logic [6:0] vbits, logic last_w);
            int unsigned full_bytes, extra_bits;
            logic [63:0] keep, tail;
            logic [7:0]  partial;
            if (!last_w) begin
                absorb(w);
                return;
            end
            if (vbits >= 7'd64) begin
                absorb(w);
                sponge[absorb_pos] ^= PAD_BYTE;
            end else begin
                full_bytes = vbits / 8;
                extra_bits = vbits % 8;
                keep = (full_bytes == 0) ? '0 : ((64'd1 << (8*full_bytes)) - 64'd1);
                partial = (8'(w >> (8*full_bytes)) & 8'(16'hFF00 >> extra_bits))
                          | 8'(8'h80 >> extra_bits);
                tail = 64'(partial) << (8*full_bytes);
                sponge[absorb_pos] ^= (w & keep) | tail;
            end
            permute_block();
            for (int k = 0; k < DIGEST_COUNT; k++)
                expected_q.push_back('{word: sponge[k], last: (k == DIGEST_COUNT - 1)});
            clear_state();
        endfunction

        function void report_mismatch(string what);
            $display("MISMATCH: %s", what);
            mismatches++;
        endfunction

        function void check_digest(logic [63:0] word, logic last);
            t_digest_beat exp_beat;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("digest word %h with none expected", word));
                return;
            end
            exp_beat = expected_q.pop_front();
            if (word !== exp_beat.word)
                report_mismatch($sformatf("digest_word got %h want %h", word, exp_beat.word));
            if (last !== exp_beat.last)
                report_mismatch($sformatf("digest_last got %b want %b", last, exp_beat.last));
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for sponge_hash_2048bit_permutation: drives message requests,
// stalls the digest channel and writes round_count; depends on sph_tb_pkg.
module tb_top;
    import sph_tb_pkg::*;

    // The limit lies far beyond the slowest correct run.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // Longest internal activity after the last result: two full permutations plus digest.
    localparam int unsigned SETTLE_CYCLES = 90;
    localparam int unsigned PHASE_ITEMS   = 38;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_msg_word;
    logic [6:0]  i_valid_bits;
    logic        i_last_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_digest_word;
    logic        o_digest_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sph_digest_scoreboard sb;

    // When set, neither side inserts idle cycles or stalls.
    bit          calm;
    int unsigned requests_sent;
    int unsigned cycle_count;

    sponge_hash_2048bit_permutation #(
        .RATE_WORDS  (RATE_COUNT),
        .DIGEST_WORDS(DIGEST_COUNT)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_msg_word   (i_msg_word),
        .i_valid_bits (i_valid_bits),
        .i_last_word  (i_last_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_digest_word(o_digest_word),
        .o_digest_last(o_digest_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost digest word ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The digest channel stalls at random, with an 11 percent chance at each edge, except in calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 11);
        end
    end

    // Every digest word accepted at this edge is checked against the oldest prediction.
    // Values read here are the ones from before the edge, as the block sees them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_digest(o_digest_word, o_digest_last);
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Message lengths: many short ones, many medium ones, and many that land right at or next to a block boundary
    // so that the pad either fits or spills into a fresh block.
    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30) begin
            return $urandom_range(4, 1);
        end else if (roll < 60) begin
            return $urandom_range(45, 5);
        end
        case ($urandom_range(5))
            0:       return 19;
            1:       return 20;
            2:       return 21;
            3:       return 39;
            4:       return 40;
            default: return 41;
        endcase
    endfunction

    // Valid-bit count of a final word: whole words, over-range counts, and partial words.
    function automatic logic [6:0] pick_tail_bits();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) begin
            return 7'd64;
        end else if (roll < 50) begin
            return 7'($urandom_range(127, 65));
        end
        return 7'($urandom_range(63));
    endfunction

    // Presents one request, at times after a random idle gap, and holds it until accepted. Called at a rising edge;
    // returns at the edge where the request was taken.
    task automatic send_word(input logic [63:0] w, input logic [6:0] vbits, input logic last_w);
        int unsigned gap;
        if (!calm && $urandom_range(99) < 11) begin
            gap = $urandom_range(4, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_msg_word   <= w;
        i_valid_bits <= vbits;
        i_last_word  <= last_w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(w, vbits, last_w);
        requests_sent++;
    endtask

    // Non-final words carry random valid_bits, which the block must ignore.
    task automatic send_message(input int unsigned len, input logic [6:0] tail_bits);
        for (int unsigned k = 1; k <= len; k++) begin
            if (k == len) begin
                send_word(rand_word(), tail_bits, 1'b1);
            end else begin
                send_word(rand_word(), 7'($urandom_range(127)), 1'b0);
            end
        end
    endtask

    // Waits for every predicted digest word, then lets the block finish any
    // permutation started by a word that produces no result.
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands at the edge with pready high.
    task automatic write_round_count(input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ROUND_COUNT;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_rounds(value);
    endtask

    initial begin
        int unsigned phase_rounds [5];
        int unsigned phase_start;
        bit          paused;

        sb            = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_msg_word    = '0;
        i_valid_bits  = '0;
        i_last_word   = 1'b0;
        i_out_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        requests_sent = 0;
        cycle_count   = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset round count of 15. An empty message, whose
        // pad bit lands in byte 0 of an otherwise zero word.
        send_word('1, 7'd0, 1'b1);
        // A whole final word: the pad goes into the next rate word.
        send_word('0, 7'd64, 1'b1);
        // A valid-bit count above 64 behaves as 64.
        send_word('1, 7'd127, 1'b1);
        // Partial final words: one bit kept, and all but the last bit kept.
        send_word(rand_word(), 7'd1, 1'b1);
        send_word(rand_word(), 7'd63, 1'b1);
        // A whole final word that fills the block: permute first, then pad a fresh block.
        send_message(RATE_COUNT, 7'd64);

        // Zero rounds make the permutation the identity.
        drain_and_settle();
        write_round_count(0);
        send_word(rand_word(), 7'd33, 1'b1);
        send_message(RATE_COUNT + 1, 7'd8);

        // Random part: round counts 1 and 31, then two random settings and the reset value 15. The second
        // phase runs without any idling on either side.
        phase_rounds[0] = 1;
        phase_rounds[1] = 31;
        phase_rounds[2] = $urandom_range(30, 2);
        phase_rounds[3] = $urandom_range(31, 1);
        phase_rounds[4] = 15;
        paused = 1'b0;
        foreach (phase_rounds[p]) begin
            drain_and_settle();
            write_round_count(phase_rounds[p]);
            calm = (p == 1);
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_ITEMS) begin
                send_message(pick_length(), pick_tail_bits());
                // Once, hold the sender back until every digest word is out.
                if (p == 2 && !paused && requests_sent - phase_start > 25) begin
                    drain_and_settle();
                    paused = 1'b1;
                end
            end
        end
        calm = 1'b0;

        drain_and_settle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sph_pkg.sv
rtl/sph_round.sv
rtl/sponge_hash_2048bit_permutation.sv
tb/sv/sph_tb_pkg.sv
tb/sv/tb_top.sv
